// ----- src/sih_pkg.sv -----
// Shared types, sizes and codes for the string intern hash table unit.
// Used by sih_ctrl, sih_dpath and the top level; no dependencies of its own.
`default_nettype none
package sih_pkg;

   localparam int BUCKET_COUNT = 1024;
   localparam int STORE_BYTES  = 65536;
   localparam int MAX_KEY_LEN  = 255;
   localparam int START_OFFSET = 42;

   localparam int TB_AW  = $clog2(BUCKET_COUNT);
   localparam int ST_AW  = $clog2(STORE_BYTES);
   localparam int KB_AW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int KB_DEPTH = 1 << KB_AW;
   localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
   localparam int OFF_W  = ST_AW;
   localparam int NF_W   = ST_AW + 1;
   localparam int NEED_W = ST_AW + 2;
   localparam int HASH_W = 64;
   localparam int BKT_W  = HASH_W + OFF_W;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_STORE_FULL = 2'd2;

   typedef struct packed {
      logic [63:0] key_hash;
      logic [7:0]  key_length;
      logic [7:0]  key_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] handle;
      logic        new_entry;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PROBE_RD, S_PROBE_CHK, S_LEN_LO, S_LEN_HI, S_LEN_CHK,
      S_BYTE_RD, S_BYTE_CHK, S_NEXT, S_INS_LO, S_INS_HI, S_INS_RD, S_INS_WR,
      S_COMMIT
   } state_type;

   typedef enum logic [1:0] {RESP_HIT, RESP_NEW, RESP_TABLE, RESP_STORE} resp_kind_type;

   typedef enum logic [1:0] {WSEL_LEN_LO, WSEL_LEN_HI, WSEL_DATA} wsel_type;

   typedef struct packed {
      logic          clear_wr;
      logic          probe_next;
      logic          off_load;
      logic          sa_inc;
      logic          lo_cap;
      logic          k_clr;
      logic          k_inc;
      logic          st_wr;
      wsel_type      wsel;
      logic          commit;
      logic          resp_en;
      resp_kind_type resp_kind;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bkt_empty;
      logic hash_eq;
      logic fits;
      logic len_eq;
      logic len_zero;
      logic k_last;
      logic byte_eq;
      logic probe_last;
   } sts_type;

endpackage
`default_nettype wire

// ----- src/sih_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sih_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/sih_ctrl.sv -----
// Controller state machine: sequences clear, probe, compare and insert.
// Depends on sih_pkg.
`default_nettype none
module sih_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             last,
   input  wire sih_pkg::sts_type sts,
   output sih_pkg::cmd_type      cmd,
   output logic                  busy
);
   import sih_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:     if (sts.clear_last) state_in = S_IDLE;
         S_IDLE:      if (accept && last) state_in = S_PROBE_RD;
         S_PROBE_RD:  state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (sts.bkt_empty) state_in = sts.fits ? S_INS_LO : S_IDLE;
            else if (sts.hash_eq) state_in = S_LEN_LO;
            else state_in = S_NEXT;
         end
         S_LEN_LO:    state_in = S_LEN_HI;
         S_LEN_HI:    state_in = S_LEN_CHK;
         S_LEN_CHK: begin
            if (!sts.len_eq) state_in = S_NEXT;
            else if (sts.len_zero) state_in = S_IDLE;
            else state_in = S_BYTE_RD;
         end
         S_BYTE_RD:   state_in = S_BYTE_CHK;
         S_BYTE_CHK: begin
            if (!sts.byte_eq) state_in = S_NEXT;
            else if (sts.k_last) state_in = S_IDLE;
            else state_in = S_BYTE_RD;
         end
         S_NEXT:      state_in = sts.probe_last ? S_IDLE : S_PROBE_RD;
         S_INS_LO:    state_in = S_INS_HI;
         S_INS_HI:    state_in = sts.len_zero ? S_COMMIT : S_INS_RD;
         S_INS_RD:    state_in = S_INS_WR;
         S_INS_WR:    state_in = sts.k_last ? S_COMMIT : S_INS_RD;
         S_COMMIT:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.wsel = WSEL_DATA;
      cmd.resp_kind = RESP_HIT;
      case (state_ff)
         S_CLEAR: cmd.clear_wr = 1'b1;
         S_PROBE_CHK: begin
            if (sts.bkt_empty) begin
               if (!sts.fits) begin
                  cmd.resp_en = 1'b1;
                  cmd.resp_kind = RESP_STORE;
               end
            end else if (sts.hash_eq) begin
               cmd.off_load = 1'b1;
            end
         end
         S_LEN_LO: cmd.sa_inc = 1'b1;
         S_LEN_HI: begin
            cmd.lo_cap = 1'b1;
            cmd.sa_inc = 1'b1;
         end
         S_LEN_CHK: begin
            cmd.k_clr = 1'b1;
            if (sts.len_eq && sts.len_zero) cmd.resp_en = 1'b1;
         end
         S_BYTE_CHK: begin
            if (sts.byte_eq) begin
               if (sts.k_last) begin
                  cmd.resp_en = 1'b1;
               end else begin
                  cmd.sa_inc = 1'b1;
                  cmd.k_inc = 1'b1;
               end
            end
         end
         S_NEXT: begin
            if (sts.probe_last) begin
               cmd.resp_en = 1'b1;
               cmd.resp_kind = RESP_TABLE;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         S_INS_LO: begin
            cmd.st_wr = 1'b1;
            cmd.wsel = WSEL_LEN_LO;
            cmd.k_clr = 1'b1;
         end
         S_INS_HI: begin
            cmd.st_wr = 1'b1;
            cmd.wsel = WSEL_LEN_HI;
         end
         S_INS_WR: begin
            cmd.st_wr = 1'b1;
            cmd.k_inc = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.resp_en = 1'b1;
            cmd.resp_kind = RESP_NEW;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ----- src/sih_dpath.sv -----
// Datapath: key buffer, bucket table, byte store and the probe registers.
// Depends on sih_pkg and sih_ram.
`default_nettype none
module sih_dpath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire sih_pkg::req_type req,
   input  wire sih_pkg::cmd_type cmd,
   output sih_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output sih_pkg::rsp_type      rsp
);
   import sih_pkg::*;

   logic [LEN_W-1:0]  fill_ff;
   logic [TB_AW-1:0]  clr_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [TB_AW-1:0]  n_ff;
   logic [TB_AW-1:0]  probes_ff;
   logic [OFF_W-1:0]  cur_off_ff;
   logic [ST_AW-1:0]  sa_ff;
   logic [7:0]        lo_ff;
   logic [KB_AW-1:0]  k_ff;
   logic [NF_W-1:0]   nf_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;

   logic [LEN_W-1:0]  len_in;
   logic              kb_wr;
   logic [7:0]        kb_rd;
   logic              bkt_wr;
   logic [TB_AW-1:0]  bkt_wr_addr;
   logic [BKT_W-1:0]  bkt_wr_data, bkt_rd;
   logic [OFF_W-1:0]  bkt_off;
   logic [HASH_W-1:0] bkt_hash;
   logic [ST_AW-1:0]  st_wr_addr;
   logic [7:0]        st_wr_data, st_rd;
   logic [15:0]       len16;
   logic [NEED_W-1:0] need;

   assign len_in = (int'(req.key_length) > MAX_KEY_LEN) ? LEN_W'(MAX_KEY_LEN)
                                                        : LEN_W'(req.key_length);
   assign kb_wr = accept && (req.key_length != 8'd0) && (int'(fill_ff) < MAX_KEY_LEN);
   assign len16 = 16'(len_ff);
   assign need = NEED_W'(nf_ff) + NEED_W'(2) + NEED_W'(len_ff);

   sih_ram #(.WIDTH(8), .DEPTH(KB_DEPTH)) u_key_buf (
      .clock   (clock),
      .wr_en   (kb_wr),
      .wr_addr (fill_ff[KB_AW-1:0]),
      .wr_data (req.key_byte),
      .rd_addr (k_ff),
      .rd_data (kb_rd)
   );

   assign bkt_wr      = cmd.clear_wr || cmd.commit;
   assign bkt_wr_addr = cmd.clear_wr ? clr_ff : n_ff;
   assign bkt_wr_data = cmd.clear_wr ? '0 : {hash_ff, nf_ff[OFF_W-1:0]};

   sih_ram #(.WIDTH(BKT_W), .DEPTH(BUCKET_COUNT)) u_buckets (
      .clock   (clock),
      .wr_en   (bkt_wr),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_addr (n_ff),
      .rd_data (bkt_rd)
   );

   assign bkt_off  = bkt_rd[OFF_W-1:0];
   assign bkt_hash = bkt_rd[BKT_W-1:OFF_W];

   always_comb begin
      case (cmd.wsel)
         WSEL_LEN_LO: begin
            st_wr_addr = nf_ff[ST_AW-1:0];
            st_wr_data = len16[7:0];
         end
         WSEL_LEN_HI: begin
            st_wr_addr = nf_ff[ST_AW-1:0] + ST_AW'(1);
            st_wr_data = len16[15:8];
         end
         default: begin
            st_wr_addr = nf_ff[ST_AW-1:0] + ST_AW'(2) + ST_AW'(k_ff);
            st_wr_data = kb_rd;
         end
      endcase
   end

   sih_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.st_wr),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (sa_ff),
      .rd_data (st_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         clr_ff        <= '0;
         nf_ff         <= NF_W'(START_OFFSET);
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (accept && req.last_byte) fill_ff <= '0;
         else if (kb_wr) fill_ff <= fill_ff + LEN_W'(1);
         if (cmd.clear_wr) clr_ff <= clr_ff + TB_AW'(1);
         if (cmd.commit) nf_ff <= need[NF_W-1:0];
         rsp_strobe_ff <= cmd.resp_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && req.last_byte) begin
         hash_ff   <= req.key_hash;
         len_ff    <= len_in;
         n_ff      <= req.key_hash[TB_AW-1:0];
         probes_ff <= '0;
      end else if (cmd.probe_next) begin
         n_ff      <= n_ff + TB_AW'(1);
         probes_ff <= probes_ff + TB_AW'(1);
      end
      if (cmd.off_load) begin
         cur_off_ff <= bkt_off;
         sa_ff      <= bkt_off;
      end else if (cmd.sa_inc) begin
         sa_ff <= sa_ff + ST_AW'(1);
      end
      if (cmd.lo_cap) lo_ff <= st_rd;
      if (cmd.k_clr) k_ff <= '0;
      else if (cmd.k_inc) k_ff <= k_ff + KB_AW'(1);
      if (cmd.resp_en) begin
         case (cmd.resp_kind)
            RESP_HIT:   rsp_ff <= '{handle: 16'(cur_off_ff), new_entry: 1'b0,
                                    status: STATUS_OK};
            RESP_NEW:   rsp_ff <= '{handle: 16'(nf_ff), new_entry: 1'b1,
                                    status: STATUS_OK};
            RESP_TABLE: rsp_ff <= '{handle: 16'd0, new_entry: 1'b0,
                                    status: STATUS_TABLE_FULL};
            default:    rsp_ff <= '{handle: 16'd0, new_entry: 1'b0,
                                    status: STATUS_STORE_FULL};
         endcase
      end
   end

   assign sts.clear_last = &clr_ff;
   assign sts.bkt_empty  = (bkt_off == '0);
   assign sts.hash_eq    = (bkt_hash == hash_ff);
   assign sts.fits       = (need <= NEED_W'(STORE_BYTES));
   assign sts.len_eq     = ({st_rd, lo_ff} == len16);
   assign sts.len_zero   = (len_ff == '0);
   assign sts.k_last     = ((LEN_W+1)'(k_ff) + (LEN_W+1)'(1)) == (LEN_W+1)'(len_ff);
   assign sts.byte_eq    = (st_rd == kb_rd);
   assign sts.probe_last = &probes_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule
`default_nettype wire

// ----- src/string_intern_hash_table_unit.sv -----
// Top level of the string intern hash table unit.
// Depends on sih_pkg, sih_ctrl and sih_dpath (which holds the sih_ram instances).
//
// Strings stream in one byte per transfer (start high while busy is low), each
// carrying the string's 64-bit hash and length; the transfer with last_byte set
// ends the string. After a byte that is not last, busy stays low.
// On the last byte the unit walks a 1024-bucket linear-probing table from
// hash mod table size, comparing hash, stored length and bytes of each
// occupied bucket, then either returns the existing byte store offset or
// appends length and bytes at the next free offset (first one is 42). Each
// probe reads its bucket and checks it, reads and checks the stored length
// when the hash matches, reads and checks each compared byte, and steps on to
// the next bucket when the bucket does not match; an insert writes the two
// length bytes, then reads and writes each key byte, then commits the bucket;
// the result strobe comes in the cycle after the last step. This sequence
// is set by the single read port of the byte store and the bucket RAM.
// Errors: table full after 1024 probes (status 1), store full (status 2),
// handle 0. The result is shown on rsp_data while rsp_strobe is high for a single
// cycle; the receiver cannot stall it, so capture it then. After reset, busy
// stays high while the bucket table is cleared one bucket per cycle.
`default_nettype none
module string_intern_hash_table_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sih_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output sih_pkg::rsp_type      rsp_data
);
   import sih_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    accept;

   // a transfer lands whenever start meets an idle unit
   assign accept = start && !busy;

   sih_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .last   (req_data.last_byte),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   sih_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule
`default_nettype wire
